### sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

    typedef enum logic [1:0] {
        REQ_PUT  = 2'd0,
        REQ_FILL = 2'd1,
        REQ_SET  = 2'd2,
        REQ_READ = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [6:0]  col;
        logic [4:0]  row;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        bad_position;
    } rsp_t;

    typedef struct packed {
        req_type_t   op;
        logic [15:0] cell_word;
        logic [6:0]  col;
        logic [4:0]  row;
        logic        pos_ok;
    } cmd_t;

    localparam logic [15:0] BLANK_CELL = 16'h0720;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

endpackage

`default_nettype wire

### sv/tcw_front.sv
// Request intake: decodes position range and stages one command.
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tcw_pkg::req_t req,
    input  logic          init_done,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output tcw_pkg::cmd_t cmd
);

    tcw_pkg::cmd_t cmd_reg;
    tcw_pkg::cmd_t cmd_next;
    logic          cmd_valid_reg;
    logic          pos_ok;

    assign pos_ok = ({1'b0, req.col} < 8'(COLUMNS)) && ({1'b0, req.row} < 6'(ROWS));

    always_comb
    begin
        cmd_next.op        = req.req_type;
        cmd_next.cell_word = {req.attribute, req.char_code};
        cmd_next.col       = req.col;
        cmd_next.row       = req.row;
        cmd_next.pos_ok    = pos_ok;
    end

    assign req_ready = init_done && (!cmd_valid_reg || cmd_ready);
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

### sv/tcw_cmd_fifo.sv
// Short command queue between intake and execution.
`default_nettype none

module tcw_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tcw_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tcw_pkg::cmd_t pop_data
);

    tcw_pkg::cmd_t              q_mem [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [tcw_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [tcw_pkg::Q_PTR_W:0]   count_reg;
    logic                        push;
    logic                        pop;

    assign push_ready = (count_reg != (tcw_pkg::Q_PTR_W + 1)'(tcw_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = q_mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (tcw_pkg::Q_PTR_W + 1)'(tcw_pkg::Q_DEPTH))
        else $error("queue count over depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

### sv/tcw_back.sv
// Execution sequencer: cell store, cursor, scroll/fill/clear sweeps, result register.
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tcw_pkg::cmd_t cmd,
    output logic          init_done,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tcw_pkg::rsp_t rsp
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS + 1);

    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM     = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] SHIFT_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_END    = RW'(ROWS);
    localparam logic [RW-1:0] ROW_BOTTOM = RW'(ROWS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_SCROLL_BLANK,
        ST_SCROLL_PUT,
        ST_FILL,
        ST_READ,
        ST_RESP
    } state_t;

    state_t        state_reg,     state_next;
    logic [AW-1:0] idx_reg,       idx_next;
    logic [CW-1:0] col_reg,       col_next;
    logic [RW-1:0] row_reg,       row_next;
    logic [15:0]   cell_reg,      cell_next;
    logic [15:0]   value_reg,     value_next;
    logic          bad_reg,       bad_next;
    tcw_pkg::rsp_t rsp_reg,       rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [AW-1:0] cur_addr;
    logic [AW-1:0] cmd_addr;

    assign cur_addr  = AW'(row_reg) * ROW_STEP + AW'(col_reg);
    assign cmd_addr  = AW'(cmd.row) * ROW_STEP + AW'(cmd.col);
    assign init_done = (state_reg != ST_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cell_next      = cell_reg;
        value_next     = value_reg;
        bad_next       = bad_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = tcw_pkg::BLANK_CELL;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg + ROW_STEP;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_CELL)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cell_next  = cmd.cell_word;
                    value_next = '0;
                    bad_next   = 1'b0;
                    unique case (cmd.op)
                        tcw_pkg::REQ_PUT:
                        begin
                            if (row_reg == ROW_END)
                            begin
                                idx_next   = '0;
                                state_next = ST_SCROLL_RD;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = cmd.cell_word;
                                if (col_reg == COL_LAST)
                                begin
                                    col_next = '0;
                                    row_next = row_reg + 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                                state_next = ST_RESP;
                            end
                        end
                        tcw_pkg::REQ_FILL:
                        begin
                            idx_next   = '0;
                            state_next = ST_FILL;
                        end
                        tcw_pkg::REQ_SET:
                        begin
                            if (cmd.pos_ok)
                            begin
                                col_next = CW'(cmd.col);
                                row_next = RW'(cmd.row);
                            end
                            else
                            begin
                                bad_next = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        tcw_pkg::REQ_READ:
                        begin
                            if (cmd.pos_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cmd_addr;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                bad_next   = 1'b1;
                                state_next = ST_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCROLL_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                if (idx_reg == SHIFT_LAST)
                begin
                    idx_next   = BOTTOM;
                    state_next = ST_SCROLL_BLANK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCROLL_RD;
                end
            end
            ST_SCROLL_BLANK:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_CELL)
                begin
                    state_next = ST_SCROLL_PUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCROLL_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = BOTTOM;
                mem_wdata  = cell_reg;
                row_next   = ROW_BOTTOM;
                col_next   = CW'(1);
                state_next = ST_RESP;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = cell_reg;
                if (idx_reg == LAST_CELL)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                value_next = rd_data_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.cell_value   = value_reg;
                    rsp_next.cursor_col   = 7'(col_reg);
                    rsp_next.cursor_row   = 5'(row_reg);
                    rsp_next.bad_position = bad_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg  <= cell_next;
        value_reg <= value_next;
        bad_reg   <= bad_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_past_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg == ROW_END) |-> (col_reg == '0))
        else $error("cursor past end with nonzero column");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL_PUT) |-> (row_reg == ROW_END))
        else $error("scroll finished without cursor past end");

endmodule

`default_nettype wire

### sv/text_console_writer.sv
// Top level of the text console writer.
// A COLUMNS x ROWS store of 16-bit cells (attribute high byte, character low
// byte) with a cursor, driven by a request channel and answering each request
// with one response transaction. After reset the store is swept to blanks,
// one cell per cycle; req_ready stays low until that sweep ends. All work
// goes through one single-port cell store, so a fill, which writes every
// cell, and a put that scrolls, which copies each row up and blanks the
// bottom row, last far longer than a put, a cursor set or a read. A finished
// request waits in its response state while the previous response is still
// held by rsp_ready low. A four-entry command queue lets requests keep
// arriving while a long scroll or fill is in progress.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tcw_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tcw_pkg::rsp_t rsp
);

    logic          init_done;
    logic          front_valid;
    logic          front_ready;
    tcw_pkg::cmd_t front_cmd;
    logic          q_valid;
    logic          q_ready;
    tcw_pkg::cmd_t q_cmd;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .init_done (init_done),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    tcw_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .init_done (init_done),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
